// ===== hw/rtl/b37_pkg.sv =====
// Shared types, constants and the glyph lookup for the base-37 name decoder.
// No dependencies.
package b37_pkg;

  localparam int unsigned NameW    = 64;
  localparam int unsigned NumCells = 12;
  localparam int unsigned DigitW   = 6;
  localparam int unsigned CharW    = 7;
  localparam int unsigned CapW     = 4;
  localparam int unsigned CntW     = $clog2(NameW);

  localparam logic [DigitW-1:0] Radix       = 6'd37;
  localparam logic [CapW-1:0]   CapReset    = 4'd13;
  localparam logic [NameW-1:0]  NameLimit   = 64'd6582952005840035281;

  localparam logic [CharW-1:0]  CharUnder   = 7'h5F;
  localparam logic [CharW-1:0]  CharLowerA  = 7'h61;
  localparam logic [CharW-1:0]  CharZero    = 7'h30;
  localparam logic [DigitW-1:0] FirstLetter = 6'd1;
  localparam logic [DigitW-1:0] FirstNumber = 6'd27;

  typedef logic [DigitW-1:0] digit_t;

  // carry handed from one cell to the next, one beat of bit stream per cycle
  typedef struct packed {
    logic valid;
    logic carry;
  } link_t;

  function automatic logic [CharW-1:0] glyph(input digit_t d);
    logic [CharW-1:0] g;
    if (d < FirstLetter) begin
      g = CharUnder;
    end else if (d < FirstNumber) begin
      g = CharLowerA + CharW'(d - FirstLetter);
    end else begin
      g = CharZero + CharW'(d - FirstNumber);
    end
    return g;
  endfunction

endpackage

// ===== hw/rtl/b37_cell.sv =====
// One base-37 digit cell: doubles its digit and adds the incoming carry,
// or shifts in the digit of the cell below. Depends on b37_pkg.
module b37_cell
  import b37_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   clear,
  input  logic   shift_en,
  input  link_t  link_in,
  input  digit_t digit_in,
  output link_t  link_out,
  output digit_t digit
);

  logic [DigitW:0] dbl;
  logic            over;
  digit_t          digit_next;

  always_comb begin
    dbl        = {digit, 1'b0} + (DigitW+1)'(link_in.carry);
    over       = dbl >= {1'b0, Radix};
    digit_next = over ? DigitW'(dbl - {1'b0, Radix}) : dbl[DigitW-1:0];
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      digit <= '0;
    end else if (shift_en) begin
      digit <= digit_in;
    end else if (link_in.valid) begin
      digit <= digit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out <= '0;
    end else begin
      link_out.valid <= link_in.valid;
      link_out.carry <= link_in.valid & over;
    end
  end

endmodule

// ===== hw/rtl/base37_name_decoder_core.sv =====
// Base-37 name decoder: a start beat takes one 64-bit name; characters follow MSB first.
// Conversion streams the 64 name bits through a skewed row of 12 digit cells and lets the
// last bit ripple through, then a check state, then 12 shifts shared between skipping
// leading zeros and emitting one character per cycle, plus one capacity test. Busy stays
// high through a valid conversion and drops sooner on a reject; results last one cycle
// each, no stall. Synchronous active-high reset clears control state, sets capacity to 13.
module base37_name_decoder_core
  import b37_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [NameW-1:0]  encoded_name,
  input  logic              cfg_we,
  input  logic [CapW-1:0]   cfg_data,
  output logic              strobe,
  output logic [CharW-1:0]  character,
  output logic              invalid,
  output logic              last
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FEED  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_CHECK = 6'b001000,
    S_SKIP  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t           state;
  logic [NameW-1:0] name_sr;
  logic [CntW-1:0]  cnt;
  logic             too_big;
  logic [CapW-1:0]  capacity;

  link_t  link   [NumCells+1];
  digit_t digits [NumCells];

  logic   accept;
  logic   shift_en;
  digit_t top;
  logic   fits;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);
  assign top    = digits[NumCells-1];
  // digit count is NumCells - cnt; it fits when count + 1 <= capacity
  assign fits   = ((CntW+1)'(capacity) + (CntW+1)'(cnt)) >= (CntW+1)'(NumCells + 1);
  assign shift_en = ((state == S_SKIP) && (top == '0)) || (state == S_EMIT);

  assign link[0].valid = (state == S_FEED);
  assign link[0].carry = (state == S_FEED) && name_sr[NameW-1];

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    b37_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (accept),
      .shift_en (shift_en),
      .link_in  (link[i]),
      .digit_in ((i == 0) ? digit_t'(0) : digits[(i == 0) ? 0 : i-1]),
      .link_out (link[i+1]),
      .digit    (digits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapReset;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      name_sr <= encoded_name;
      too_big <= encoded_name >= NameLimit;
    end else if (state == S_FEED) begin
      name_sr <= {name_sr[NameW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      strobe    <= 1'b0;
      invalid   <= 1'b0;
      last      <= 1'b0;
      character <= '0;
    end else begin
      strobe    <= 1'b0;
      invalid   <= 1'b0;
      last      <= 1'b0;
      character <= '0;
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (start) begin
            state <= S_FEED;
          end
        end
        S_FEED: begin
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(NameW - 1)) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // let the last bit ripple through the remaining cells
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(NumCells - 2)) begin
            cnt   <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // a zero low digit covers both zero and multiples of 37
          if (too_big || (digits[0] == '0)) begin
            strobe  <= 1'b1;
            invalid <= 1'b1;
            last    <= 1'b1;
            state   <= S_IDLE;
          end else begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (top == '0) begin
            cnt <= cnt + 1'b1;
          end else if (!fits) begin
            strobe  <= 1'b1;
            invalid <= 1'b1;
            last    <= 1'b1;
            state   <= S_IDLE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          strobe    <= 1'b1;
          character <= glyph(top);
          cnt       <= cnt + 1'b1;
          if (cnt == CntW'(NumCells - 1)) begin
            last  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/b37_checker.sv =====
// Port-level checks for the base-37 name decoder, bound to the top level.
// Depends on b37_pkg and base37_name_decoder_core.
module b37_checker
  import b37_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             strobe,
  input logic [CharW-1:0] character,
  input logic             invalid,
  input logic             last
);

  a_more_while_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final character seen while block idle");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("block still busy on final beat");

  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    strobe && invalid |-> last && (character == '0))
    else $error("reject beat malformed");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !strobe)
    else $error("accepted name did not start conversion");

endmodule

bind base37_name_decoder_core b37_checker u_b37_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .character (character),
  .invalid   (invalid),
  .last      (last)
);

// ===== sim/b37_decode_checker.sv =====
// Checker for the base-37 name decoder: follows start/busy and strobe beats, spells each
// accepted name from the tracked capacity and compares every character beat in order.
// Depends on b37_pkg.
module b37_decode_checker
  import b37_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [NameW-1:0] encoded_name,
  input  logic             cfg_we,
  input  logic [CapW-1:0]  cfg_data,
  input  logic             strobe,
  input  logic [CharW-1:0] character,
  input  logic             invalid,
  input  logic             last,
  output int unsigned      mismatches,
  output int unsigned      chars_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             bad;
    logic             fin;
  } char_beat_t;

  char_beat_t      char_q[$];
  logic [CapW-1:0] capacity;
  int unsigned     errs;

  function automatic logic [CharW-1:0] digit_char(input int d);
    if (d == 0) return CharUnder;
    if (d < int'(FirstNumber)) return CharLowerA + CharW'(d - 1);
    return CharZero + CharW'(d - int'(FirstNumber));
  endfunction

  function automatic void spell_name(input logic [NameW-1:0] name,
                                     input logic [CapW-1:0]  cap);
    logic [NameW-1:0] rest;
    int               digit [NumCells];
    int               n;
    rest = name;
    n = 0;
    if (name == '0 || name >= NameLimit || name % NameW'(Radix) == '0) begin
      char_q.push_back('{ch: '0, bad: 1'b1, fin: 1'b1});
      return;
    end
    // least significant digit first
    while (rest != '0 && n < NumCells) begin
      digit[n] = int'(rest % NameW'(Radix));
      rest = rest / NameW'(Radix);
      n++;
    end
    // one place stays reserved for the terminator
    if (n + 1 > int'(cap)) begin
      char_q.push_back('{ch: '0, bad: 1'b1, fin: 1'b1});
      return;
    end
    for (int k = n - 1; k >= 0; k--) begin
      char_q.push_back('{ch: digit_char(digit[k]), bad: 1'b0, fin: (k == 0)});
    end
  endfunction

  task automatic check_field(input string what, input logic [CharW-1:0] want_v,
                             input logic [CharW-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    char_beat_t want;
    if (rst) begin
      capacity = CapReset;
      char_q.delete();
      errs = 0;
    end else begin
      if (cfg_we) capacity = cfg_data;
      if (start && !busy) spell_name(encoded_name, capacity);
      if (strobe) begin
        if (char_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, char %h invalid %b last %b",
                   $time, character, invalid, last);
          errs++;
        end else begin
          want = char_q.pop_front();
          check_field("character", want.ch, character);
          check_field("invalid", CharW'(want.bad), CharW'(invalid));
          check_field("last", CharW'(want.fin), CharW'(last));
        end
      end
    end
    mismatches <= errs;
    chars_due  <= char_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the base-37 name decoder bench: clock, reset, name and capacity stimulus,
// watchdog and verdict. Depends on b37_pkg, base37_name_decoder_core, b37_decode_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import b37_pkg::*;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned DrainCycles  = 100;
  localparam int unsigned Blocks       = 6;
  localparam int unsigned RandPerBlock = 36;
  localparam logic [NameW-1:0] Pow11   = NameLimit / NameW'(Radix);

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  logic [NameW-1:0] encoded_name;
  logic             cfg_we;
  logic [CapW-1:0]  cfg_data;
  logic             strobe;
  logic [CharW-1:0] character;
  logic             invalid;
  logic             last;
  int unsigned      mismatches;
  int unsigned      chars_due;
  int unsigned      quiet;
  int unsigned      idle_pct;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  base37_name_decoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .encoded_name (encoded_name),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .strobe       (strobe),
    .character    (character),
    .invalid      (invalid),
    .last         (last)
  );

  b37_decode_checker chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .encoded_name (encoded_name),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .strobe       (strobe),
    .character    (character),
    .invalid      (invalid),
    .last         (last),
    .mismatches   (mismatches),
    .chars_due    (chars_due)
  );

  // count cycles in which no beat moves on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet <= 0;
    end else if (quiet >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // mostly well-formed names of random length, the rest noise and rejects
  function automatic logic [NameW-1:0] make_name();
    logic [NameW-1:0] v;
    int               n;
    int               pick;
    int               d;
    pick = $urandom_range(99);
    if (pick < 10) return {$urandom, $urandom};
    if (pick < 14) return NameLimit + NameW'($urandom_range(3));
    n = $urandom_range(NumCells, 1);
    v = '0;
    for (int i = 0; i < n; i++) begin
      d = (i == 0 || i == n - 1) ? $urandom_range(36, 1) : $urandom_range(36, 0);
      v = v * NameW'(Radix) + NameW'(d);
    end
    if (pick < 22) v = v - v % NameW'(Radix);
    return v;
  endfunction

  // hold start until the beat is taken; leave it high for a back-to-back beat
  task automatic send_name(input logic [NameW-1:0] name);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    encoded_name <= name;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    do @(posedge clk); while (chars_due != 0 || busy);
  endtask

  task automatic set_capacity(input logic [CapW-1:0] cap);
    wait_drain();
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    encoded_name = '0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    idle_pct     = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // corners at the reset capacity
    send_name('0);
    send_name(NameW'(Radix));
    send_name(64'd1);
    send_name(64'd36);
    send_name(64'd26);
    send_name(64'd27);
    send_name(64'd38);
    send_name(64'd6851);
    send_name(NameLimit - 1);
    send_name(NameLimit);
    send_name('1);
    send_name(64'h8000_0000_0000_0000);
    send_name(Pow11);
    send_name(Pow11 + 1);

    // capacity limits: twelve digits need thirteen places
    set_capacity(4'd12);
    send_name(NameLimit - 1);
    send_name(Pow11 + 1);
    send_name(Pow11 - 1);
    set_capacity(4'd1);
    send_name(64'd1);
    set_capacity(4'd2);
    send_name(64'd1);
    send_name(64'd38);
    set_capacity(4'd0);
    send_name(64'd1);
    set_capacity(4'd15);
    send_name(NameLimit - 1);

    for (int b = 0; b < Blocks; b++) begin
      idle_pct = (b < 2) ? 33 : (b < 4) ? 64 : 0;
      if (b == 0) set_capacity(CapReset);
      else if (b == 3) set_capacity(CapW'($urandom_range(15, 0)));
      else set_capacity(CapW'($urandom_range(15, 3)));
      repeat (RandPerBlock) send_name(make_name());
    end

    wait_drain();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && chars_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== base37_name_decoder_core.f =====
hw/rtl/b37_pkg.sv
hw/rtl/b37_cell.sv
hw/rtl/base37_name_decoder_core.sv
hw/rtl/b37_checker.sv
sim/b37_decode_checker.sv
sim/tb_top.sv
